### src/fw2d_pkg.sv
// Shared types, constants and the control store for the 2-D binary indexed tree block.
`timescale 1ns / 1ps

package fw2d_pkg;

    // Default grid size limits handed to the top-level parameters.
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Tree coordinates are 1-based and reach at most 64 plus its lowest set bit.
    localparam int COORD_W = 8;
    localparam int CFG_W   = 7;
    localparam int FIELD_W = 6;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register select, taken from the word address bit of paddr.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_CLEAR,
        ACT_IDLE,
        ACT_CHECK,
        ACT_LOAD,
        ACT_WALK,
        ACT_DELTA,
        ACT_URD,
        ACT_UWR,
        ACT_OUT
    } t_act;

    typedef enum logic [1:0] {
        ROW_TOP,
        ROW_TOP1,
        ROW_BOT1
    } t_row_sel;

    typedef enum logic [1:0] {
        COL_LEFT,
        COL_LEFT1,
        COL_RIGHT1
    } t_col_sel;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_act     act;
        t_row_sel row_sel;
        t_col_sel col_sel;
        logic     neg;
        t_step    target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_act     act;
        t_row_sel row_sel;
        t_col_sel col_sel;
        logic     neg;
        logic     accept;
    } t_ctrl;

    // Branch conditions from the datapath back to the sequencer.
    typedef struct packed {
        logic clr_last;
        logic oor;
        logic x_zero;
        logic x_over;
        logic y_over;
        logic out_free;
    } t_stat;

    // Entry points of the program.
    localparam t_step S_CLEAR = 5'd0;
    localparam t_step S_IDLE  = 5'd1;
    localparam t_step S_URD   = 5'd12;
    localparam t_step S_QUERY = 5'd14;

    function automatic t_uword uw(input t_act act, input t_row_sel rs, input t_col_sel cs,
                                  input logic neg, input t_step target);
        t_uword w;
        w.act     = act;
        w.row_sel = rs;
        w.col_sel = cs;
        w.neg     = neg;
        w.target  = target;
        return w;
    endfunction

    // The program. A set in the grid in use adds four signed prefix sums to recover the old
    // value, then walks the update path; a query adds four such sums and emits the total.
    function automatic t_uword urom(input t_step step);
        t_uword w;
        case (step)
            5'd0:  w = uw(ACT_CLEAR, ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd1:  w = uw(ACT_IDLE,  ROW_TOP,  COL_LEFT,   1'b0, S_QUERY);
            5'd2:  w = uw(ACT_CHECK, ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd3:  w = uw(ACT_LOAD,  ROW_TOP1, COL_LEFT1,  1'b0, S_IDLE);
            5'd4:  w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd5:  w = uw(ACT_LOAD,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd6:  w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd7:  w = uw(ACT_LOAD,  ROW_TOP1, COL_LEFT,   1'b1, S_IDLE);
            5'd8:  w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd9:  w = uw(ACT_LOAD,  ROW_TOP,  COL_LEFT1,  1'b1, S_IDLE);
            5'd10: w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd11: w = uw(ACT_DELTA, ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd12: w = uw(ACT_URD,   ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd13: w = uw(ACT_UWR,   ROW_TOP,  COL_LEFT,   1'b0, S_URD);
            5'd14: w = uw(ACT_LOAD,  ROW_BOT1, COL_RIGHT1, 1'b0, S_IDLE);
            5'd15: w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd16: w = uw(ACT_LOAD,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd17: w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd18: w = uw(ACT_LOAD,  ROW_BOT1, COL_LEFT,   1'b1, S_IDLE);
            5'd19: w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd20: w = uw(ACT_LOAD,  ROW_TOP,  COL_RIGHT1, 1'b1, S_IDLE);
            5'd21: w = uw(ACT_WALK,  ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            5'd22: w = uw(ACT_OUT,   ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
            default: w = uw(ACT_NOP, ROW_TOP,  COL_LEFT,   1'b0, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

### src/fw2d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fw2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/fw2d_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module fw2d_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    input  fw2d_pkg::t_stat i_stat,
    output fw2d_pkg::t_ctrl o_ctrl,
    output logic            o_in_stall
);

    fw2d_pkg::t_step  r_step;
    fw2d_pkg::t_step  n_step;
    fw2d_pkg::t_step  step_inc;
    fw2d_pkg::t_uword w;

    assign w        = fw2d_pkg::urom(r_step);
    assign step_inc = r_step + fw2d_pkg::t_step'(1);

    always_comb begin
        n_step = step_inc;
        case (w.act)
            fw2d_pkg::ACT_CLEAR: begin
                if (!i_stat.clr_last) n_step = r_step;
            end
            fw2d_pkg::ACT_IDLE: begin
                if (!i_in_valid) n_step = r_step;
                else if (i_opcode) n_step = w.target;
            end
            fw2d_pkg::ACT_CHECK: begin
                if (i_stat.oor) n_step = w.target;
            end
            fw2d_pkg::ACT_WALK: begin
                if (!i_stat.x_zero) n_step = r_step;
            end
            fw2d_pkg::ACT_URD: begin
                if (i_stat.x_over) n_step = w.target;
                else if (i_stat.y_over) n_step = r_step;
            end
            fw2d_pkg::ACT_OUT: begin
                n_step = i_stat.out_free ? w.target : r_step;
            end
            fw2d_pkg::ACT_LOAD, fw2d_pkg::ACT_DELTA: begin
                n_step = step_inc;
            end
            default: begin
                n_step = w.target;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fw2d_pkg::S_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_stall     = (w.act != fw2d_pkg::ACT_IDLE);
    assign o_ctrl.act     = w.act;
    assign o_ctrl.row_sel = w.row_sel;
    assign o_ctrl.col_sel = w.col_sel;
    assign o_ctrl.neg     = w.neg;
    assign o_ctrl.accept  = i_in_valid && (w.act == fw2d_pkg::ACT_IDLE);

endmodule

### src/fw2d_dp.sv
// Datapath: tree walk registers, accumulator, tree store and result register.
`timescale 1ns / 1ps

module fw2d_dp #(
    parameter int MAX_ROWS = fw2d_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = fw2d_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fw2d_pkg::t_ctrl                     i_ctrl,
    output fw2d_pkg::t_stat                     o_stat,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_top_row,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_left_col,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_bottom_row,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_right_col,
    input  logic signed [fw2d_pkg::DATA_W-1:0]  i_cell_value,
    input  logic [fw2d_pkg::COORD_W-1:0]        i_eff_rows,
    input  logic [fw2d_pkg::COORD_W-1:0]        i_eff_cols,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [fw2d_pkg::DATA_W-1:0]  o_region_sum
);

    localparam int CW    = fw2d_pkg::COORD_W;
    localparam int DW    = fw2d_pkg::DATA_W;
    localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RAW + CAW;
    localparam int DEPTH = 2 ** AW;

    function automatic logic [CW-1:0] low_bit(input logic [CW-1:0] v);
        return v & (~v + CW'(1));
    endfunction

    logic [fw2d_pkg::FIELD_W-1:0] r_top;
    logic [fw2d_pkg::FIELD_W-1:0] r_left;
    logic [fw2d_pkg::FIELD_W-1:0] r_bot;
    logic [fw2d_pkg::FIELD_W-1:0] r_right;
    logic [DW-1:0]                r_val;
    logic [CW-1:0]                r_x;
    logic [CW-1:0]                r_y;
    logic [CW-1:0]                r_yb;
    logic                         r_neg;
    logic                         r_pend;
    logic                         r_pend_neg;
    logic [DW-1:0]                r_acc;
    logic [DW-1:0]                r_delta;
    logic                         r_out_valid;
    logic [DW-1:0]                r_out_sum;
    logic [AW-1:0]                r_clr;

    logic [CW-1:0] row_bound;
    logic [CW-1:0] col_bound;
    logic [CW-1:0] row_clamp;
    logic [CW-1:0] col_clamp;
    logic [CW-1:0] top1;
    logic [CW-1:0] left1;
    logic [CW-1:0] x_m1;
    logic [CW-1:0] y_m1;
    logic [AW-1:0] addr;
    logic          x_zero;
    logic          y_zero;
    logic          x_over;
    logic          y_over;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [DW-1:0] ram_rdata;

    assign top1  = CW'(r_top) + CW'(1);
    assign left1 = CW'(r_left) + CW'(1);

    always_comb begin
        case (i_ctrl.row_sel)
            fw2d_pkg::ROW_TOP:  row_bound = CW'(r_top);
            fw2d_pkg::ROW_TOP1: row_bound = top1;
            fw2d_pkg::ROW_BOT1: row_bound = CW'(r_bot) + CW'(1);
            default:            row_bound = '0;
        endcase
        case (i_ctrl.col_sel)
            fw2d_pkg::COL_LEFT:   col_bound = CW'(r_left);
            fw2d_pkg::COL_LEFT1:  col_bound = left1;
            fw2d_pkg::COL_RIGHT1: col_bound = CW'(r_right) + CW'(1);
            default:              col_bound = '0;
        endcase
    end

    assign row_clamp = (row_bound > i_eff_rows) ? i_eff_rows : row_bound;
    assign col_clamp = (col_bound > i_eff_cols) ? i_eff_cols : col_bound;

    assign x_m1     = r_x - CW'(1);
    assign y_m1     = r_y - CW'(1);
    assign addr     = {RAW'(x_m1), CAW'(y_m1)};
    assign x_zero   = (r_x == '0);
    assign y_zero   = (r_y == '0);
    assign x_over   = (r_x > i_eff_rows);
    assign y_over   = (r_y > i_eff_cols);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr;
        ram_wdata = ram_rdata + r_delta;
        ram_re    = 1'b0;
        case (i_ctrl.act)
            fw2d_pkg::ACT_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            fw2d_pkg::ACT_WALK: ram_re = !x_zero && !y_zero;
            fw2d_pkg::ACT_URD:  ram_re = !x_over && !y_over;
            fw2d_pkg::ACT_UWR:  ram_we = 1'b1;
            default:            ram_re = 1'b0;
        endcase
    end

    fw2d_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.act == fw2d_pkg::ACT_CLEAR) r_clr <= r_clr + AW'(1);
            r_pend <= ram_re && (i_ctrl.act == fw2d_pkg::ACT_WALK);
            if (i_ctrl.act == fw2d_pkg::ACT_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_acc <= r_pend_neg ? (r_acc - ram_rdata) : (r_acc + ram_rdata);
        end
        case (i_ctrl.act)
            fw2d_pkg::ACT_IDLE: begin
                if (i_ctrl.accept) begin
                    r_top   <= i_top_row;
                    r_left  <= i_left_col;
                    r_bot   <= i_bottom_row;
                    r_right <= i_right_col;
                    r_val   <= i_cell_value;
                    r_acc   <= '0;
                end
            end
            fw2d_pkg::ACT_LOAD: begin
                r_x   <= row_clamp;
                r_y   <= col_clamp;
                r_yb  <= col_clamp;
                r_neg <= i_ctrl.neg;
            end
            fw2d_pkg::ACT_WALK: begin
                if (!x_zero) begin
                    if (y_zero) begin
                        r_x <= r_x - low_bit(r_x);
                        r_y <= r_yb;
                    end else begin
                        r_pend_neg <= r_neg;
                        r_y        <= r_y - low_bit(r_y);
                    end
                end
            end
            fw2d_pkg::ACT_DELTA: begin
                r_delta <= r_val - r_acc;
                r_x     <= top1;
                r_y     <= left1;
                r_yb    <= left1;
            end
            fw2d_pkg::ACT_URD: begin
                if (!x_over && y_over) begin
                    r_x <= r_x + low_bit(r_x);
                    r_y <= r_yb;
                end
            end
            fw2d_pkg::ACT_UWR: begin
                r_y <= r_y + low_bit(r_y);
            end
            fw2d_pkg::ACT_OUT: begin
                if (out_free) r_out_sum <= r_acc;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    assign o_stat.clr_last = &r_clr;
    assign o_stat.oor      = (CW'(r_top) >= i_eff_rows) || (CW'(r_left) >= i_eff_cols);
    assign o_stat.x_zero   = x_zero;
    assign o_stat.x_over   = x_over;
    assign o_stat.y_over   = y_over;
    assign o_stat.out_free = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_region_sum = r_out_sum;

`ifndef SYNTH
    // The last prefix read has been folded in before the total is used.
    a_no_pend_at_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == fw2d_pkg::ACT_DELTA || i_ctrl.act == fw2d_pkg::ACT_OUT) |-> !r_pend)
        else $error("prefix read still pending when the sum is used");

    // A write-back always follows the read of the same tree node.
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == fw2d_pkg::ACT_UWR) |-> $past(ram_re))
        else $error("tree write-back without a preceding read");

    // Prefix walks never step outside the clamped grid.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == fw2d_pkg::ACT_WALK && !x_zero) |-> (r_x <= i_eff_rows && r_y <= i_eff_cols))
        else $error("prefix walk outside the grid in use");
`endif

endmodule

### src/fenwick_2d_point_set_region_sum_top.sv
// Top level of the 2-D binary indexed tree: configuration registers, sequencer and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_top_row, i_left_col,
//                                                i_bottom_row, i_right_col, i_cell_value
// output    out        o_out_valid / i_out_stall o_region_sum
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A query walks four prefix sums, reading one tree cell at a time, and emits the total;
// a set recovers the old value from four prefix walks, and its update path costs a read
// and a write per node. The single read port of the tree store reads one node per cycle.
// After reset the tree store is cleared one word a cycle, MAX_ROWS' by MAX_COLS' words
// (each rounded up to a power of two, 4096 words by default); no beat is accepted meanwhile.
// One result beat may wait in the output register while the next input beat is taken.

module fenwick_2d_point_set_region_sum_top #(
    parameter int MAX_ROWS = fw2d_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = fw2d_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_top_row,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_left_col,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_bottom_row,
    input  logic [fw2d_pkg::FIELD_W-1:0]        i_right_col,
    input  logic signed [fw2d_pkg::DATA_W-1:0]  i_cell_value,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [fw2d_pkg::DATA_W-1:0]  o_region_sum,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fw2d_pkg::PADDR_W-1:0]        paddr,
    input  logic [fw2d_pkg::PDATA_W-1:0]        pwdata,
    output logic [fw2d_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int CW = fw2d_pkg::COORD_W;

    logic [fw2d_pkg::CFG_W-1:0] r_rows_in_use;
    logic [fw2d_pkg::CFG_W-1:0] r_cols_in_use;
    logic [CW-1:0]              eff_rows;
    logic [CW-1:0]              eff_cols;
    logic                       cfg_wr;

    fw2d_pkg::t_ctrl ctrl;
    fw2d_pkg::t_stat stat;

    // The register file is always ready; a write lands in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= fw2d_pkg::CFG_W'(64);
            r_cols_in_use <= fw2d_pkg::CFG_W'(64);
        end else if (cfg_wr) begin
            case (paddr[2])
                fw2d_pkg::REG_ROWS: r_rows_in_use <= pwdata[fw2d_pkg::CFG_W-1:0];
                fw2d_pkg::REG_COLS: r_cols_in_use <= pwdata[fw2d_pkg::CFG_W-1:0];
                default:            r_rows_in_use <= r_rows_in_use;
            endcase
        end
    end

    assign prdata = (paddr[2] == fw2d_pkg::REG_COLS) ? fw2d_pkg::PDATA_W'(r_cols_in_use)
                                                     : fw2d_pkg::PDATA_W'(r_rows_in_use);

    // A register value above the grid size behaves as the grid size.
    assign eff_rows = (11'(r_rows_in_use) > 11'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(r_rows_in_use);
    assign eff_cols = (11'(r_cols_in_use) > 11'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_cols_in_use);

    fw2d_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    fw2d_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_bottom_row (i_bottom_row),
        .i_right_col  (i_right_col),
        .i_cell_value (i_cell_value),
        .i_eff_rows   (eff_rows),
        .i_eff_cols   (eff_cols),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_region_sum (o_region_sum)
    );

endmodule

### bench/fenwick_2d_point_set_region_sum_top_test.sv
// Self-checking testbench for the 2-D binary indexed tree block: set cells, query rectangles.
`timescale 1ns / 1ps

// The bench runs a directed table first and then random traffic in several register
// phases. An in-bench model of the tree predicts the rectangle sums. Sets give no result
// beat, so the model only updates its own copy of the tree for them. Every query pushes one
// expected sum. The output monitor checks each result beat against the oldest expected sum.
module fenwick_2d_point_set_region_sum_top_test;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int GRID_ROWS      = fw2d_pkg::MAX_ROWS_DEF;
    localparam int GRID_COLS      = fw2d_pkg::MAX_COLS_DEF;
    localparam int DW             = fw2d_pkg::DATA_W;
    localparam int FW             = fw2d_pkg::FIELD_W;
    localparam int AW             = fw2d_pkg::PADDR_W;
    // A set yields no beat to wait for. This is the settling time before a register write
    // and at the end of the run.
    localparam int SETTLE_CYCLES  = 400;
    // This covers the clearing pass after reset (4096 words) with a wide margin.
    localparam int WATCHDOG_LIMIT = 30000;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register i sits at byte address 4*i. The word select bit comes from the package.
    localparam logic [AW-1:0] ROWS_ADDR = {fw2d_pkg::REG_ROWS, 2'b00};
    localparam logic [AW-1:0] COLS_ADDR = {fw2d_pkg::REG_COLS, 2'b00};

    // These are the register settings of the random phases. They include zero, the grid
    // size and the all-ones value, which exceeds the grid and should act as the grid size.
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ROWS  [NUM_PHASES] = '{64, 127, 8, 0, 64, 1, 33, 64};
    localparam int PHASE_COLS  [NUM_PHASES] = '{64, 127, 8, 64, 0, 64, 17, 64};
    localparam int PHASE_BEATS [NUM_PHASES] = '{160, 160, 160, 40, 40, 120, 160, 190};
    localparam int CALM_PHASE = 1;
    localparam int HOLD_PHASE = 2;

    typedef struct packed {
        logic          op;
        logic [FW-1:0] r1;
        logic [FW-1:0] c1;
        logic [FW-1:0] r2;
        logic [FW-1:0] c2;
        logic [DW-1:0] value;
    } t_cell_beat;

    typedef enum logic [1:0] {
        PLAN_BEAT,
        PLAN_ROWS,
        PLAN_COLS
    } t_plan_kind;

    // A register row carries its register value in the value field. A beat row with known set
    // carries an expected sum that is read straight off the grid contents.
    typedef struct packed {
        t_plan_kind    kind;
        t_cell_beat    beat;
        logic          known;
        logic [DW-1:0] known_sum;
    } t_plan_row;

    localparam int PLAN_LEN = 26;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // A freshly cleared tree sums to zero everywhere.
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b1, 32'h0},
        // The corner cells take the extreme values. The unused rectangle fields hold junk.
        '{PLAN_BEAT, '{OP_SET,   6'd0,  6'd0,  6'd63, 6'd63, 32'h7FFF_FFFF}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd63, 6'd63, 6'd0,  6'd0,  32'h8000_0000}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd63, 6'd0,  6'd21, 6'd42, 32'hFFFF_FFFF}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd0,  6'd63, 6'd42, 6'd21, 32'h0000_0001}, 1'b0, 32'h0},
        // The cell value of a query is ignored.
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000}, 1'b0, 32'h0},
        // These two rectangles are reversed, one in both axes and one in the rows alone.
        '{PLAN_BEAT, '{OP_QUERY, 6'd63, 6'd63, 6'd0,  6'd0,  32'h5555_AAAA}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd5,  6'd0,  6'd4,  6'd63, 32'h0000_0000}, 1'b0, 32'h0},
        // This overwrites a cell that already holds a value.
        '{PLAN_BEAT, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'h1234_5678}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b0, 32'h0},
        // With no rows in use, sets are dropped and every prefix clamps to nothing.
        '{PLAN_ROWS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd0},         1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd3,  6'd3,  6'd9,  6'd9,  32'hAAAA_5555}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b1, 32'h0},
        // A register above the grid size acts as the grid size.
        '{PLAN_ROWS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd127},       1'b0, 32'h0},
        '{PLAN_COLS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd127},       1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b0, 32'h0},
        // On a one by one grid, a set one step outside it is dropped.
        '{PLAN_ROWS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd1},         1'b0, 32'h0},
        '{PLAN_COLS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd1},         1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd1,  6'd0,  6'd0,  6'd0,  32'd99},        1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd0,  6'd1,  6'd0,  6'd0,  32'd99},        1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'h5A5A_0F0F}, 1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b0, 32'h0},
        // When the grid grows back, the tree is walked as the small grid left it.
        '{PLAN_ROWS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd64},        1'b0, 32'h0},
        '{PLAN_COLS, '{OP_SET,   6'd0,  6'd0,  6'd0,  6'd0,  32'd64},        1'b0, 32'h0},
        '{PLAN_BEAT, '{OP_QUERY, 6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000}, 1'b0, 32'h0}
    };

    // Every input of the block starts at a known value.
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_opcode     = OP_SET;
    logic [FW-1:0]        i_top_row    = '0;
    logic [FW-1:0]        i_left_col   = '0;
    logic [FW-1:0]        i_bottom_row = '0;
    logic [FW-1:0]        i_right_col  = '0;
    logic signed [DW-1:0] i_cell_value = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [AW-1:0]        paddr        = '0;
    logic [fw2d_pkg::PDATA_W-1:0] pwdata = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic signed [DW-1:0] o_region_sum;
    logic [fw2d_pkg::PDATA_W-1:0] prdata;
    logic                 pready;

    // The bench keeps its own copy of the tree and of the two registers.
    logic [DW-1:0] tree_copy [GRID_ROWS*GRID_COLS];
    logic [6:0]    rows_shadow = 7'd64;
    logic [6:0]    cols_shadow = 7'd64;
    logic [DW-1:0] pending_sums [$];
    logic [DW-1:0] sum_due;
    int            fail_count = 0;
    int            quiet_run  = 0;
    // While calm is set, neither side idles.
    bit            calm = 1'b0;

    fenwick_2d_point_set_region_sum_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_bottom_row (i_bottom_row),
        .i_right_col  (i_right_col),
        .i_cell_value (i_cell_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_region_sum (o_region_sum),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic int unsigned rows_limit();
        return (rows_shadow > GRID_ROWS) ? GRID_ROWS : rows_shadow;
    endfunction

    function automatic int unsigned cols_limit();
        return (cols_shadow > GRID_COLS) ? GRID_COLS : cols_shadow;
    endfunction

    // This is the sum over the 1-based rows 1..r and columns 1..c. Both bounds are clamped
    // to the grid in use.
    function automatic logic [DW-1:0] corner_sum(input int unsigned r, input int unsigned c);
        int unsigned   x;
        int unsigned   y;
        logic [DW-1:0] acc;
        acc = '0;
        if (r > rows_limit()) r = rows_limit();
        if (c > cols_limit()) c = cols_limit();
        for (x = r; x > 0; x -= x & (~x + 1))
            for (y = c; y > 0; y -= y & (~y + 1))
                acc += tree_copy[(x - 1) * GRID_COLS + (y - 1)];
        return acc;
    endfunction

    function automatic logic [DW-1:0] rectangle_sum(input t_cell_beat b);
        int unsigned r1;
        int unsigned c1;
        int unsigned r2;
        int unsigned c2;
        r1 = 32'(b.r1);
        c1 = 32'(b.c1);
        r2 = b.r2 + 1;
        c2 = b.c2 + 1;
        return corner_sum(r2, c2) + corner_sum(r1, c1) - corner_sum(r2, c1)
               - corner_sum(r1, c2);
    endfunction

    // A set first recovers the cell's old value. It then adds the change along the update
    // path. A cell outside the rows or columns in use is left alone.
    task automatic store_cell(input t_cell_beat b);
        int unsigned   r;
        int unsigned   c;
        int unsigned   x;
        int unsigned   y;
        logic [DW-1:0] old_value;
        logic [DW-1:0] change;
        if (b.r1 >= rows_limit() || b.c1 >= cols_limit())
            return;
        r = b.r1 + 1;
        c = b.c1 + 1;
        old_value = corner_sum(r, c) + corner_sum(r - 1, c - 1) - corner_sum(r, c - 1)
                    - corner_sum(r - 1, c);
        change = b.value - old_value;
        for (x = r; x >= 1 && x <= rows_limit(); x += x & (~x + 1))
            for (y = c; y >= 1 && y <= cols_limit(); y += y & (~y + 1))
                tree_copy[(x - 1) * GRID_COLS + (y - 1)] += change;
    endtask

    // A beat is presented at one edge. The task then waits for the edge that takes it, and
    // valid stays high. The accepted beat goes into the model in this same process, so the
    // expected sums keep the order in which the beats were accepted.
    task automatic send_beat(input t_cell_beat b, input logic known,
                             input logic [DW-1:0] known_sum);
        i_in_valid   <= 1'b1;
        i_opcode     <= b.op;
        i_top_row    <= b.r1;
        i_left_col   <= b.c1;
        i_bottom_row <= b.r2;
        i_right_col  <= b.c2;
        i_cell_value <= b.value;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (b.op == OP_QUERY)
            pending_sums.push_back(known ? known_sum : rectangle_sum(b));
        else
            store_cell(b);
    endtask

    // This stops sending until every expected sum has come back. It waits on the clock before
    // it first checks the queue, so the next drive of valid falls in a later time step.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_sums.size() != 0);
    endtask

    // A register is written only when the block is quiet. A set gives no beat to wait for,
    // so the task also waits out the longest set. Each write is read back at once.
    task automatic program_reg(input logic [AW-1:0] addr, input logic [6:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(fw2d_pkg::PDATA_W - 7){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ROWS_ADDR)
            rows_shadow = value;
        else
            cols_shadow = value;
        // The read setup follows straight on. psel stays high.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[6:0] !== value)
            report_mismatch("register read-back", prdata, DW'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The index is in the grid in use most of the time and anywhere in the field otherwise.
    function automatic logic [FW-1:0] pick_index(input int unsigned lim);
        if (lim > 0 && $urandom_range(0, 99) < 85)
            return FW'($urandom_range(0, lim - 1));
        return FW'($urandom_range(0, 63));
    endfunction

    function automatic t_cell_beat random_beat();
        t_cell_beat  b;
        logic [FW-1:0] a;
        logic [FW-1:0] z;
        int unsigned pick;
        b.op    = ($urandom_range(0, 99) < 45) ? OP_QUERY : OP_SET;
        b.r1    = FW'($urandom_range(0, 63));
        b.c1    = FW'($urandom_range(0, 63));
        b.r2    = FW'($urandom_range(0, 63));
        b.c2    = FW'($urandom_range(0, 63));
        b.value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            b.value = 32'h8000_0000;
        else if (pick < 6)
            b.value = 32'h7FFF_FFFF;
        else if (pick < 8)
            b.value = 32'hFFFF_FFFF;
        else if (pick < 10)
            b.value = '0;
        if (b.op == OP_SET) begin
            b.r1 = pick_index(rows_limit());
            b.c1 = pick_index(cols_limit());
        end else if ($urandom_range(0, 99) < 80) begin
            // The rectangle is well formed, with its corners in the grid in use when possible.
            a = pick_index(rows_limit());
            z = pick_index(rows_limit());
            b.r1 = (a < z) ? a : z;
            b.r2 = (a < z) ? z : a;
            a = pick_index(cols_limit());
            z = pick_index(cols_limit());
            b.c1 = (a < z) ? a : z;
            b.c2 = (a < z) ? z : a;
        end
        return b;
    endfunction

    // The receiver stalls in about a quarter of the cycles, except during the calm phase.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    // Each accepted result beat must match the oldest expected sum.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("result beat with no query waiting", o_region_sum, 'x);
            end else begin
                sum_due = pending_sums.pop_front();
                if (o_region_sum !== sum_due)
                    report_mismatch("region_sum", o_region_sum, sum_due);
            end
        end
    end

    // The watchdog ends the run when no beat is accepted on either channel for too long.
    initial begin : watchdog
        while (quiet_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0)
                    || (o_out_valid === 1'b1 && !i_out_stall))
                quiet_run = 0;
            else
                quiet_run++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int         row;
        int         ph;
        int         n;
        t_cell_beat b;
        foreach (tree_copy[k]) tree_copy[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. The first beat is held off by the clearing pass of the tree store.
        for (row = 0; row < PLAN_LEN; row++) begin
            case (PLAN[row].kind)
                PLAN_ROWS: begin
                    program_reg(ROWS_ADDR, PLAN[row].beat.value[6:0]);
                end
                PLAN_COLS: begin
                    program_reg(COLS_ADDR, PLAN[row].beat.value[6:0]);
                end
                default: begin
                    send_beat(PLAN[row].beat, PLAN[row].known, PLAN[row].known_sum);
                end
            endcase
        end

        // Random traffic, one register setting per phase. Most sets land in the grid in use,
        // so the tree fills up and the queries have real sums to check.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            program_reg(ROWS_ADDR, 7'(PHASE_ROWS[ph]));
            program_reg(COLS_ADDR, 7'(PHASE_COLS[ph]));
            calm = (ph == CALM_PHASE);
            for (n = 0; n < PHASE_BEATS[ph]; n++) begin
                if (ph == HOLD_PHASE && n == PHASE_BEATS[ph] / 2)
                    drain_results();
                if (!calm && $urandom_range(0, 99) < 26) begin
                    // Most gaps are short. A few are long enough to span a whole set.
                    i_in_valid <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(20, 300)) @(posedge i_clk);
                    else
                        repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
                b = random_beat();
                send_beat(b, 1'b0, '0);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
src/fw2d_pkg.sv
src/fw2d_ram.sv
src/fw2d_seq.sv
src/fw2d_dp.sv
src/fenwick_2d_point_set_region_sum_top.sv
bench/fenwick_2d_point_set_region_sum_top_test.sv
